// ===== design/ritd_pkg.sv =====
// Package for the radix integer-to-digits converter.
// Holds payload structs, register codes, sequencer states and the alphabet lookup.
// No dependencies.
`default_nettype none

package ritd_pkg;

  localparam int VALUE_W        = 63;
  localparam int VALUE_BITS_DEF = 63;
  localparam int BASE_W         = 5;
  localparam int CHAR_W         = 8;
  localparam int ALPHA_W        = 64;
  localparam int DIGIT_W        = 4;
  localparam int STEP_BITS      = 8;
  localparam int CFG_IDX_W      = 1;

  localparam logic [BASE_W-1:0]  BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX   = 5'd16;
  localparam logic [CHAR_W-1:0]  ZERO_CHAR  = 8'h30;
  localparam logic [CHAR_W-1:0]  ERROR_CHAR = 8'h00;
  localparam logic [ALPHA_W-1:0] ALPHA_LOW_RST  = 64'h3736353433323130;
  localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RST = 64'h4645444342413938;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [BASE_W-1:0]  base;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
    logic              base_error;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_LOAD,
    S_SPECIAL
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_to_char(
    input logic [ALPHA_W-1:0] alo,
    input logic [ALPHA_W-1:0] ahi,
    input logic [DIGIT_W-1:0] d
  );
    logic [ALPHA_W-1:0] word;
    word = d[3] ? ahi : alo;
    return word[{d[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

// ===== design/radix_integer_to_digits_core.sv =====
// Per digit: a pass of the shared divide unit over the value in 8-bit chunks (8 quotient bits a cycle),
// then per emitted character a stack read and an output load once all digits are known.
// A zero value or a bad base skips the divide unit and the stack and emits a single character.
// One conversion at a time; input stalls from accept until the last character is loaded.
// Reset: sequencer idle, output empty, alphabet back to 0-9 then A-F.
`default_nettype none

module radix_integer_to_digits_core #(
  parameter int VALUE_BITS = ritd_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire ritd_pkg::in_t                in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output ritd_pkg::out_t                    out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [ritd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ritd_pkg::ALPHA_W-1:0] cfg_data_i
);
  import ritd_pkg::*;

  localparam int Chunks = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int W      = Chunks * STEP_BITS;
  localparam int ChW    = (Chunks > 1) ? $clog2(Chunks) : 1;
  localparam int AW     = $clog2(VALUE_BITS);
  localparam int CntW   = $clog2(VALUE_BITS + 1);

  state_e               state_q, state_d;
  logic [W-1:0]         val_q, val_d;
  logic [W-1:0]         quo_q, quo_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic [BASE_W-1:0]    base_q, base_d;
  logic [ChW-1:0]       chunk_q, chunk_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic                 err_q, err_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;
  logic [ALPHA_W-1:0]   alo_q, alo_d;
  logic [ALPHA_W-1:0]   ahi_q, ahi_d;

  logic [DIGIT_W-1:0]   mem_q [VALUE_BITS];
  logic [DIGIT_W-1:0]   rd_q;
  logic                 mem_we;

  logic [STEP_BITS-1:0] win;
  logic [STEP_BITS-1:0] qbits;
  logic [DIGIT_W-1:0]   rem_next;
  logic [W-1:0]         quo_next;
  logic [W-1:0]         in_val;
  logic                 base_bad;
  logic                 out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_val      = W'(in_data_i.value[VALUE_BITS-1:0]);
  assign base_bad    = (in_data_i.base < BASE_MIN) || (in_data_i.base > BASE_MAX);
  assign win         = val_q[W-1 -: STEP_BITS];

  // restoring division, eight quotient bits a cycle
  always_comb begin
    logic [DIGIT_W:0] t;
    logic [DIGIT_W-1:0] r;
    r     = rem_q;
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, win[STEP_BITS-1-i]};
      if (t >= base_q) begin
        t = t - base_q;
        qbits[STEP_BITS-1-i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
    quo_next = W'({quo_q, qbits});
  end

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    base_d      = base_q;
    chunk_d     = chunk_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    alo_d       = alo_q;
    ahi_d       = ahi_q;
    mem_we      = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA_LOW:  alo_d = cfg_data_i;
        CFG_ALPHA_HIGH: ahi_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (base_bad) begin
            err_d   = 1'b1;
            state_d = S_SPECIAL;
          end else if (in_val == '0) begin
            err_d   = 1'b0;
            state_d = S_SPECIAL;
          end else begin
            val_d   = in_val;
            base_d  = in_data_i.base;
            rem_d   = '0;
            chunk_d = '0;
            cnt_d   = '0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        val_d   = val_q << STEP_BITS;
        quo_d   = quo_next;
        rem_d   = rem_next;
        chunk_d = chunk_q + 1'b1;
        if (chunk_q == ChW'(Chunks - 1)) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          if (quo_next == '0) begin
            ptr_d   = cnt_q[AW-1:0];
            state_d = S_READ;
          end else begin
            val_d   = quo_next;
            rem_d   = '0;
            chunk_d = '0;
          end
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.digit_char = digit_to_char(alo_q, ahi_q, rd_q);
          out_d.last_digit = (ptr_q == '0);
          out_d.base_error = 1'b0;
          if (ptr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q - 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_SPECIAL: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.digit_char = err_q ? ERROR_CHAR : ZERO_CHAR;
          out_d.last_digit = 1'b1;
          out_d.base_error = err_q;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chunk_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      alo_q       <= ALPHA_LOW_RST;
      ahi_q       <= ALPHA_HIGH_RST;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      alo_q       <= alo_d;
      ahi_q       <= ahi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    ptr_q  <= ptr_d;
    err_q  <= err_d;
    out_q  <= out_d;
  end

  // digit stack: push least significant first, pop most significant first
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[AW-1:0]] <= rem_next;
    end
    rd_q <= mem_q[ptr_q];
  end

endmodule

`default_nettype wire

// ===== design/ritd_checker.sv =====
// Port-level checks for the radix integer-to-digits converter.
// Depends on ritd_pkg; bound to radix_integer_to_digits_core below.
`default_nettype none

module ritd_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire ritd_pkg::out_t out_data_o,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i
);
  import ritd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.base_error |->
      out_data_o.last_digit && (out_data_o.digit_char == ERROR_CHAR))
    else $error("error beat malformed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after accept");

  a_busy_mid_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_digit |-> in_stall_o)
    else $error("input open before last digit");

endmodule

bind radix_integer_to_digits_core ritd_checker u_ritd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire
